[rtl/core/clts_pkg.sv]
// Shared types, byte codes and character classes for the token splitter.
`default_nettype none

package clts_pkg;

    // Depth of the queue between the lexer front and the output back.
    localparam int QDepth = 4;

    // Byte codes that steer the lexer.
    localparam logic [7:0] ChTab        = 8'd9;
    localparam logic [7:0] ChLineFeed   = 8'd10;
    localparam logic [7:0] ChSpace      = 8'd32;
    localparam logic [7:0] ChBang       = 8'd33;
    localparam logic [7:0] ChDquote     = 8'd34;
    localparam logic [7:0] ChPercent    = 8'd37;
    localparam logic [7:0] ChAmp        = 8'd38;
    localparam logic [7:0] ChSquote     = 8'd39;
    localparam logic [7:0] ChStar       = 8'd42;
    localparam logic [7:0] ChPlus       = 8'd43;
    localparam logic [7:0] ChMinus      = 8'd45;
    localparam logic [7:0] ChDot        = 8'd46;
    localparam logic [7:0] ChSlash      = 8'd47;
    localparam logic [7:0] ChDigit0     = 8'd48;
    localparam logic [7:0] ChDigit9     = 8'd57;
    localparam logic [7:0] ChLess       = 8'd60;
    localparam logic [7:0] ChEqual      = 8'd61;
    localparam logic [7:0] ChGreater    = 8'd62;
    localparam logic [7:0] ChUpperA     = 8'd65;
    localparam logic [7:0] ChUpperZ     = 8'd90;
    localparam logic [7:0] ChUnderscore = 8'd95;
    localparam logic [7:0] ChLowerA     = 8'd97;
    localparam logic [7:0] ChLowerZ     = 8'd122;
    localparam logic [7:0] ChBar        = 8'd124;

    // Lexer modes.
    typedef enum logic [2:0] {
        ModeIdle = 3'd0,
        ModeWord = 3'd1,
        ModeOp   = 3'd2,
        ModeDq   = 3'd3,
        ModeSq   = 3'd4
    } lex_mode_t;

    // One result: a token byte and its end flag.
    typedef struct packed {
        logic [7:0] token_byte;
        logic       token_end;
    } slot_t;

    // One queue entry holds the one or two results of an input beat.
    typedef struct packed {
        logic           two;
        slot_t [1:0]    slots;
    } entry_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic is_word(input logic [7:0] b);
        return ((b >= ChLowerA) && (b <= ChLowerZ)) ||
               ((b >= ChUpperA) && (b <= ChUpperZ)) ||
               ((b >= ChDigit0) && (b <= ChDigit9)) ||
               (b == ChUnderscore) || (b == ChDot);
    endfunction

    function automatic logic is_sep(input logic [7:0] b);
        return (b == ChTab) || (b == ChLineFeed) || (b == ChSpace);
    endfunction

    // Bytes that may open a two-byte operator.
    function automatic logic is_op_start(input logic [7:0] b);
        return (b == ChEqual) || (b == ChLess) || (b == ChGreater) ||
               (b == ChBang) || (b == ChStar) || (b == ChPlus) ||
               (b == ChMinus) || (b == ChPercent) || (b == ChSlash) ||
               (b == ChAmp) || (b == ChBar);
    endfunction

    // True when the held byte and the new byte form one operator.
    function automatic logic pairs(input logic [7:0] first, input logic [7:0] second);
        logic eq_form;
        logic doubled;
        eq_form = (first != ChAmp) && (first != ChBar) && (second == ChEqual);
        doubled = ((first == ChPlus) || (first == ChMinus) || (first == ChAmp) ||
                   (first == ChBar)) && (second == first);
        return eq_form || doubled;
    endfunction

endpackage

`default_nettype wire

[rtl/core/clts_front.sv]
// Lexer front: accepts text beats, tracks the token state and queues results.
`default_nettype none

module clts_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,   // [7:0] text_byte
    input  wire logic                s_tlast,   // text_end
    input  wire clts_pkg::q_status_t q_status,
    output logic                     q_push,
    output clts_pkg::entry_t         q_wdata
);
    import clts_pkg::*;

    lex_mode_t  mode_reg, mode_next;
    logic [7:0] held_reg, held_next;
    logic       held_valid_reg, held_valid_next;

    logic       fire;
    logic [1:0] cnt;
    slot_t [1:0] res;
    logic       start;
    logic [7:0] b;

    assign s_tready = !q_status.full;
    assign fire     = s_tvalid && s_tready;
    assign b        = s_tdata;

    // Next state and results of one text beat.
    always_comb begin
        mode_next       = mode_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        cnt             = 2'd0;
        res             = '0;
        start           = 1'b0;

        if ((mode_reg == ModeWord) && held_valid_reg) begin
            res[0].token_byte = held_reg;
            cnt               = 2'd1;
            if (is_word(b)) begin
                held_next = b;
            end else begin
                res[0].token_end = 1'b1;
                start            = 1'b1;
            end
        end else if ((mode_reg == ModeOp) && held_valid_reg) begin
            res[0].token_byte = held_reg;
            if (pairs(held_reg, b)) begin
                res[1].token_byte = b;
                res[1].token_end  = 1'b1;
                cnt               = 2'd2;
                mode_next         = ModeIdle;
                held_valid_next   = 1'b0;
                held_next         = 8'd0;
            end else begin
                res[0].token_end = 1'b1;
                cnt              = 2'd1;
                start            = 1'b1;
            end
        end else if ((mode_reg == ModeDq) || (mode_reg == ModeSq)) begin
            res[0].token_byte = b;
            cnt               = 2'd1;
            if (b == ((mode_reg == ModeDq) ? ChDquote : ChSquote)) begin
                res[0].token_end = 1'b1;
                mode_next        = ModeIdle;
            end
        end else begin
            start = 1'b1;
        end

        // A byte that opens afresh, also once the held token has ended.
        if (start) begin
            mode_next       = ModeIdle;
            held_valid_next = 1'b0;
            if (is_sep(b)) begin
                mode_next = ModeIdle;
            end else if (is_word(b)) begin
                held_next       = b;
                held_valid_next = 1'b1;
                mode_next       = ModeWord;
            end else if (is_op_start(b)) begin
                held_next       = b;
                held_valid_next = 1'b1;
                mode_next       = ModeOp;
            end else begin
                res[cnt[0]].token_byte = b;
                res[cnt[0]].token_end  = !((b == ChDquote) || (b == ChSquote));
                cnt                    = cnt + 2'd1;
                if (b == ChDquote) begin
                    mode_next = ModeDq;
                end else if (b == ChSquote) begin
                    mode_next = ModeSq;
                end
            end
        end

        // End of text flushes the held byte or closes an open literal.
        if (s_tlast) begin
            if (held_valid_next) begin
                res[cnt[0]].token_byte = held_next;
                res[cnt[0]].token_end  = 1'b1;
                cnt                    = cnt + 2'd1;
            end else if (((mode_next == ModeDq) || (mode_next == ModeSq)) &&
                         (cnt != 2'd0)) begin
                res[cnt[0] ^ 1'b1].token_end = 1'b1;
            end
            mode_next       = ModeIdle;
            held_valid_next = 1'b0;
            held_next       = 8'd0;
        end
    end

    assign q_push        = fire && (cnt != 2'd0);
    assign q_wdata.two   = cnt[1];
    assign q_wdata.slots = res;

    // Lexer state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= ModeIdle;
            held_reg       <= 8'd0;
            held_valid_reg <= 1'b0;
        end else if (fire) begin
            mode_reg       <= mode_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/clts_queue.sv]
// Short queue of result entries between the lexer front and the output back.
`default_nettype none

module clts_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire clts_pkg::entry_t    wdata,
    input  wire logic                pop,
    output clts_pkg::entry_t         rdata,
    output clts_pkg::q_status_t      status
);
    import clts_pkg::*;

    localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int CntW = $clog2(QDepth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(QDepth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(QDepth);

    entry_t          mem_reg [QDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CntFull);
    assign status.empty = (count_reg == '0);
    assign rdata        = mem_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && status.full))
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && status.empty))
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntFull)
        else $error("queue fill count beyond depth");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue fill count missed a write");
`endif

endmodule

`default_nettype wire

[rtl/core/clts_back.sv]
// Output back: takes queue entries and sends their results one beat at a time.
`default_nettype none

module clts_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire clts_pkg::entry_t    q_rdata,
    input  wire clts_pkg::q_status_t q_status,
    output logic                     q_pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,   // [7:0] token_byte
    output logic                     m_tlast,   // token_end
    output logic                     m_tuser    // run_last
);
    import clts_pkg::*;

    entry_t ent_reg;
    logic   have_reg;
    logic   sel_reg;
    logic   fire;
    logic   done_cur;
    logic   load;
    slot_t  cur;

    assign cur      = ent_reg.slots[sel_reg];
    assign m_tvalid = have_reg;
    assign m_tdata  = cur.token_byte;
    assign m_tlast  = cur.token_end;
    assign m_tuser  = sel_reg || !ent_reg.two;

    assign fire     = m_tvalid && m_tready;
    assign done_cur = fire && m_tuser;
    assign load     = !have_reg || done_cur;
    assign q_pop    = load && !q_status.empty;

    // Entry holding register and result select.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
            sel_reg  <= 1'b0;
        end else if (q_pop) begin
            have_reg <= 1'b1;
            sel_reg  <= 1'b0;
        end else if (done_cur) begin
            have_reg <= 1'b0;
            sel_reg  <= 1'b0;
        end else if (fire) begin
            sel_reg  <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ent_reg <= q_rdata;
        end
    end

`ifndef SYNTHESIS
    a_second_only_pairs: assert property (@(posedge aclk) disable iff (!aresetn)
        (have_reg && sel_reg) |-> ent_reg.two)
        else $error("second result selected in a single-result entry");
    a_first_then_second: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && ent_reg.two && !sel_reg) |=> (have_reg && sel_reg))
        else $error("second result of a pair was skipped");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(sel_reg)))
        else $error("result select moved during a stall");
`endif

endmodule

`default_nettype wire

[rtl/core/c_like_lexer_token_splitter_unit.sv]
// Top level of the C-style token splitter: lexer front, result queue, output back.
//
//  channel | dir | handshake         | tdata          | tlast      | tuser
//  s_      | in  | s_tvalid/s_tready | [7:0] text     | text_end   | -
//  m_      | out | m_tvalid/m_tready | [7:0] token    | token_end  | run_last
//
// The front takes one text beat per cycle while the four-entry queue has room.
// Each text beat yields zero, one or two token beats; the back sends one token
// beat per cycle while m_tready is high, so a stream of two-result beats is
// limited by the single output port of the back.
// A text beat is registered in the queue and then in the back's entry register.
// Synchronous active-low reset clears the lexer mode, held byte and queue.
// A stalled output fills the queue and then holds s_tready low.
`default_nettype none

module c_like_lexer_token_splitter_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] text_byte
    input  wire logic       s_tlast,   // text_end
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] token_byte
    output logic            m_tlast,   // token_end
    output logic            m_tuser    // run_last
);
    import clts_pkg::*;

    q_status_t q_status;
    logic      q_push;
    logic      q_pop;
    entry_t    q_wdata;
    entry_t    q_rdata;

    clts_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_status (q_status),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    clts_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .status  (q_status)
    );

    clts_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_rdata  (q_rdata),
        .q_status (q_status),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
